// ===== rtl/wps_pkg.sv =====
// Shared types and constants for the waypoint path stepper.
package wps_pkg;

  localparam int MaxPoints    = 64;
  localparam int FractionBits = 16;
  localparam int SlotW        = 6;
  localparam int CountW       = 7;
  localparam int CoordW       = 16;
  localparam int SpeedW       = 8;

  // Square-root and divide iteration counts.
  localparam int RootSteps = 17 + FractionBits;
  localparam int DivSteps  = 25 + 2 * FractionBits;

  typedef enum logic [1:0] {
    KIND_MOVE  = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_LAST  = 2'd2
  } kind_e;

  typedef enum logic {
    CMD_LOAD    = 1'b0,
    CMD_ADVANCE = 1'b1
  } cmd_e;

  typedef enum logic {
    REG_GROUND_COUNT = 1'b0,
    REG_AERIAL_COUNT = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic                     command;
    logic                     path_select;
    logic [SlotW-1:0]         point_slot;
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic [CountW-1:0]        segment_in;
    logic signed [CoordW-1:0] pos_x;
    logic signed [CoordW-1:0] pos_y;
    logic [SpeedW-1:0]        step_speed;
  } in_item_t;

  typedef struct packed {
    logic signed [CoordW-1:0] next_x;
    logic signed [CoordW-1:0] next_y;
    logic [CountW-1:0]        segment_out;
    logic                     arrived;
  } out_item_t;

  // Classified step handed from the front end to the back end.
  typedef struct packed {
    kind_e                    kind;
    logic [CountW-1:0]        seg;
    logic [CountW-1:0]        n;
    logic signed [CoordW-1:0] px;
    logic signed [CoordW-1:0] py;
    logic signed [CoordW-1:0] x1;
    logic signed [CoordW-1:0] y1;
    logic signed [CoordW-1:0] x2;
    logic signed [CoordW-1:0] y2;
    logic [SpeedW-1:0]        speed;
  } job_t;

endpackage

// ===== rtl/wps_front.sv =====
// Front end: accepts beats, holds the path tables and classifies each step.
module wps_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [6:0]        cfg_wdata_i,
  input  logic              push,
  output logic              full,
  input  wps_pkg::in_item_t in_item_i,
  output logic              job_push_o,
  output wps_pkg::job_t     job_o,
  input  logic              job_full_i
);
  import wps_pkg::*;

  logic [CountW-1:0] gnd_cnt_q, aer_cnt_q;
  logic [31:0]       mem_q [2*MaxPoints];
  logic [31:0]       rda_q, rdb_q;
  logic              fs_v_q;
  job_t              fs_q;

  logic              accept, acc_load, acc_adv;
  logic [CountW-1:0] cnt, n, seg;
  logic              is_empty, is_last;
  logic [SlotW-1:0]  addr_a, addr_b;

  assign full       = fs_v_q && job_full_i;
  assign accept     = push && !full;
  assign acc_load   = accept && (in_item_i.command == CMD_LOAD);
  assign acc_adv    = accept && (in_item_i.command == CMD_ADVANCE);
  assign job_push_o = fs_v_q && !job_full_i;

  // Classify the step and pick the two table entries to read.
  always_comb begin
    cnt      = in_item_i.path_select ? aer_cnt_q : gnd_cnt_q;
    n        = (cnt > CountW'(MaxPoints)) ? CountW'(MaxPoints) : cnt;
    seg      = (in_item_i.segment_in == '0) ? CountW'(1) : in_item_i.segment_in;
    is_empty = (n == '0);
    is_last  = (seg >= n);
    addr_a   = is_last ? SlotW'(n - CountW'(1)) : SlotW'(seg - CountW'(1));
    addr_b   = seg[SlotW-1:0];
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gnd_cnt_q <= '0;
      aer_cnt_q <= '0;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_GROUND_COUNT: gnd_cnt_q <= cfg_wdata_i;
        REG_AERIAL_COUNT: aer_cnt_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Path tables: write on load beats, read both endpoints on advance beats.
  always_ff @(posedge clk_i) begin
    if (acc_load) begin
      mem_q[{in_item_i.path_select, in_item_i.point_slot}] <=
        {in_item_i.point_x, in_item_i.point_y};
    end
    if (acc_adv) begin
      rda_q <= mem_q[{in_item_i.path_select, addr_a}];
      rdb_q <= mem_q[{in_item_i.path_select, addr_b}];
    end
  end

  // Hold the classified step until the queue takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_v_q <= 1'b0;
    end else if (acc_adv) begin
      fs_v_q <= 1'b1;
    end else if (job_push_o) begin
      fs_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_adv) begin
      fs_q.kind  <= is_empty ? KIND_EMPTY : (is_last ? KIND_LAST : KIND_MOVE);
      fs_q.seg   <= seg;
      fs_q.n     <= n;
      fs_q.px    <= in_item_i.pos_x;
      fs_q.py    <= in_item_i.pos_y;
      fs_q.speed <= in_item_i.step_speed;
      fs_q.x1    <= '0;
      fs_q.y1    <= '0;
      fs_q.x2    <= '0;
      fs_q.y2    <= '0;
    end
  end

  // Merge the table read data into the step.
  always_comb begin
    job_o    = fs_q;
    job_o.x1 = rda_q[31:16];
    job_o.y1 = rda_q[15:0];
    job_o.x2 = rdb_q[31:16];
    job_o.y2 = rdb_q[15:0];
  end

  a_adv_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_adv |=> fs_v_q)
    else $error("advance beat lost in front stage");

endmodule

// ===== rtl/wps_job_queue.sv =====
// Short queue of classified steps between the front and back ends.
module wps_job_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  wps_pkg::job_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output wps_pkg::job_t data_o,
  output logic          empty_o
);
  import wps_pkg::*;

  job_t       buf_q [4];
  logic [1:0] wr_q, rd_q;
  logic [2:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 3'd4);
  assign empty_o = (cnt_q == 3'd0);
  assign data_o  = buf_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wr_q] <= data_i;
    end
  end

  // Advance pointers and occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 2'd1;
      if (do_pop)  rd_q <= rd_q + 2'd1;
      cnt_q <= cnt_q + 3'(do_push) - 3'(do_pop);
    end
  end

endmodule

// ===== rtl/wps_back.sv =====
// Back end: segment length, step quotient, position update and result queue.
module wps_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  wps_pkg::job_t      job_i,
  input  logic               job_empty_i,
  output logic               job_pop_o,
  output logic               empty,
  input  logic               pop,
  output wps_pkg::out_item_t out_item_o
);
  import wps_pkg::*;

  localparam int RootFirst = 2;
  localparam int DivFirst  = RootFirst + RootSteps;
  localparam int SumStage  = DivFirst + DivSteps;
  localparam int RndStage  = SumStage + 1;
  localparam int ResStage  = SumStage + 2;
  localparam int NumStages = ResStage + 1;

  typedef struct packed {
    job_t               job;
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic [33:0]        sqx;
    logic [33:0]        sqy;
    logic [33:0]        d2;
    logic [24:0]        ax;
    logic [24:0]        ay;
    logic [32:0]        root;
    logic [35:0]        rrem;
    logic [34:0]        remx;
    logic [34:0]        remy;
    logic [39:0]        qx;
    logic [39:0]        qy;
    logic signed [41:0] sumx;
    logic signed [41:0] sumy;
    logic signed [25:0] nx;
    logic signed [25:0] ny;
    out_item_t          res;
  } pipe_t;

  pipe_t                 pipe_q  [NumStages];
  pipe_t                 pipe_nx [NumStages];
  pipe_t                 seed;
  logic [NumStages-1:0]  vld_q;
  logic                  adv;

  out_item_t             oq_q [2];
  logic                  oq_wr_q, oq_rd_q;
  logic [1:0]            oq_cnt_q;
  logic                  oq_push, oq_pop;

  function automatic logic signed [41:0] axis_sum(input logic signed [15:0] pos,
                                                   input logic neg,
                                                   input logic [39:0] q);
    logic signed [41:0] base;
    logic signed [41:0] qe;
    base = {{10{pos[15]}}, pos, 16'b0};
    qe   = {2'b00, q};
    return neg ? base - qe : base + qe;
  endfunction

  // Round toward zero while dropping the fraction.
  function automatic logic signed [25:0] axis_trunc(input logic signed [41:0] s);
    logic signed [41:0] b;
    b = s + (s[41] ? 42'sh0FFFF : 42'sh0);
    return b[41:16];
  endfunction

  function automatic pipe_t stage_fn(input int k, input pipe_t p);
    pipe_t              o;
    int                 i;
    logic [16:0]        magx, magy;
    logic [1:0]         pair;
    logic [35:0]        rr, tt;
    logic [24:0]        shx, shy;
    logic [34:0]        rx, ry, dd;
    logic signed [25:0] lox, hix, loy, hiy, x1s, y1s, x2s, y2s;
    logic               snap;
    logic [CountW-1:0]  segn;
    o = p;
    if (k == 0) begin
      // Segment deltas, squares and speed products.
      o.dx  = {p.job.x2[15], p.job.x2} - {p.job.x1[15], p.job.x1};
      o.dy  = {p.job.y2[15], p.job.y2} - {p.job.y1[15], p.job.y1};
      magx  = o.dx[16] ? 17'(-o.dx) : 17'(o.dx);
      magy  = o.dy[16] ? 17'(-o.dy) : 17'(o.dy);
      o.sqx = 34'(o.dx * o.dx);
      o.sqy = 34'(o.dy * o.dy);
      o.ax  = 25'(p.job.speed * magx[15:0]);
      o.ay  = 25'(p.job.speed * magy[15:0]);
    end else if (k == 1) begin
      o.d2   = p.sqx + p.sqy;
      o.root = '0;
      o.rrem = '0;
      o.remx = '0;
      o.remy = '0;
      o.qx   = '0;
      o.qy   = '0;
    end else if (k < DivFirst) begin
      // One digit of the square root.
      i    = k - RootFirst;
      pair = 2'b00;
      if (i < 17) pair = 2'(p.d2 >> (32 - 2 * i));
      rr     = {p.rrem[33:0], pair};
      tt     = 36'({p.root, 2'b01});
      o.root = {p.root[31:0], 1'b0};
      if (rr >= tt) begin
        o.rrem    = rr - tt;
        o.root[0] = 1'b1;
      end else begin
        o.rrem = rr;
      end
    end else if (k < SumStage) begin
      // One quotient bit of each axis step.
      i    = k - DivFirst;
      shx  = p.ax << i;
      shy  = p.ay << i;
      rx   = {p.remx[33:0], shx[24]};
      ry   = {p.remy[33:0], shy[24]};
      dd   = 35'(p.root);
      o.qx = {p.qx[38:0], 1'b0};
      o.qy = {p.qy[38:0], 1'b0};
      if (rx >= dd) begin
        o.remx  = rx - dd;
        o.qx[0] = 1'b1;
      end else begin
        o.remx = rx;
      end
      if (ry >= dd) begin
        o.remy  = ry - dd;
        o.qy[0] = 1'b1;
      end else begin
        o.remy = ry;
      end
    end else if (k == SumStage) begin
      o.sumx = axis_sum(p.job.px, p.dx[16], p.qx);
      o.sumy = axis_sum(p.job.py, p.dy[16], p.qy);
    end else if (k == RndStage) begin
      o.nx = axis_trunc(p.sumx);
      o.ny = axis_trunc(p.sumy);
    end else begin
      // Bounding box and endpoint checks, then build the result.
      x1s  = 26'(p.job.x1);
      y1s  = 26'(p.job.y1);
      x2s  = 26'(p.job.x2);
      y2s  = 26'(p.job.y2);
      lox  = (x1s < x2s) ? x1s : x2s;
      hix  = (x1s < x2s) ? x2s : x1s;
      loy  = (y1s < y2s) ? y1s : y2s;
      hiy  = (y1s < y2s) ? y2s : y1s;
      snap = (p.d2 == '0) || (p.nx < lox) || (p.nx > hix) ||
             (p.ny < loy) || (p.ny > hiy) ||
             ((p.nx == x1s) && (p.ny == y1s)) || ((p.nx == x2s) && (p.ny == y2s));
      segn = snap ? p.job.seg + CountW'(1) : p.job.seg;
      case (p.job.kind)
        KIND_EMPTY: begin
          o.res.next_x      = p.job.px;
          o.res.next_y      = p.job.py;
          o.res.segment_out = '0;
          o.res.arrived     = 1'b1;
        end
        KIND_LAST: begin
          o.res.next_x      = p.job.x1;
          o.res.next_y      = p.job.y1;
          o.res.segment_out = p.job.n;
          o.res.arrived     = 1'b1;
        end
        default: begin
          o.res.next_x      = snap ? p.job.x2 : p.nx[15:0];
          o.res.next_y      = snap ? p.job.y2 : p.ny[15:0];
          o.res.segment_out = segn;
          o.res.arrived     = (segn >= p.job.n);
        end
      endcase
    end
    return o;
  endfunction

  // Whole pipeline moves unless the last beat cannot enter the result queue.
  assign adv       = !vld_q[NumStages-1] || (oq_cnt_q != 2'd2);
  assign job_pop_o = adv && !job_empty_i;
  assign oq_push   = adv && vld_q[NumStages-1];
  assign oq_pop    = pop && !empty;

  always_comb begin
    seed     = '0;
    seed.job = job_i;
  end

  always_comb begin
    pipe_nx[0] = stage_fn(0, seed);
    for (int k = 1; k < NumStages; k++) begin
      pipe_nx[k] = stage_fn(k, pipe_q[k-1]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pipe_q <= pipe_nx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NumStages-2:0], job_pop_o};
    end
  end

  // Two-entry result queue.
  assign empty      = (oq_cnt_q == 2'd0);
  assign out_item_o = oq_q[oq_rd_q];

  always_ff @(posedge clk_i) begin
    if (oq_push) begin
      oq_q[oq_wr_q] <= pipe_q[NumStages-1].res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wr_q  <= 1'b0;
      oq_rd_q  <= 1'b0;
      oq_cnt_q <= '0;
    end else begin
      if (oq_push) oq_wr_q <= !oq_wr_q;
      if (oq_pop)  oq_rd_q <= !oq_rd_q;
      oq_cnt_q <= oq_cnt_q + 2'(oq_push) - 2'(oq_pop);
    end
  end

  a_oq_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    oq_cnt_q != 2'd3)
    else $error("result queue overfilled");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    oq_push |-> (oq_cnt_q != 2'd2))
    else $error("result pushed into full queue");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[NumStages-1] && !adv) |=> vld_q[NumStages-1])
    else $error("stalled result dropped");

endmodule

// ===== rtl/waypoint_path_stepper.sv =====
// Throughput: one beat per cycle unless the pipeline stalls; square root and divide are unrolled one digit a stage.
// Load beats give no result; the table write lands at once.
// The pipeline stalls as a whole only while the two-entry result queue is full.
// Reset clears both point counts and all valid state; table entries hold nothing until loaded.
module waypoint_path_stepper (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [6:0]         cfg_wdata_i,
  input  logic               push,
  output logic               full,
  input  wps_pkg::in_item_t  in_item_i,
  output logic               empty,
  input  logic               pop,
  output wps_pkg::out_item_t out_item_o
);
  import wps_pkg::*;

  job_t fe_job, q_job;
  logic fe_push, q_full, q_pop, q_empty;

  wps_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item_i),
    .job_push_o  (fe_push),
    .job_o       (fe_job),
    .job_full_i  (q_full)
  );

  wps_job_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fe_push),
    .data_i  (fe_job),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_job),
    .empty_o (q_empty)
  );

  wps_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (q_job),
    .job_empty_i (q_empty),
    .job_pop_o   (q_pop),
    .empty       (empty),
    .pop         (pop),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== verif/waypoint_path_stepper_tb.sv =====
// Self-checking testbench for the waypoint path stepper.
`timescale 1ns / 100ps

module waypoint_path_stepper_tb;
  import wps_pkg::*;

  // Hold the path tables and point counts, predict each advance beat, check results.
  class path_scoreboard;
    logic signed [CoordW-1:0] pt_x[2][MaxPoints];
    logic signed [CoordW-1:0] pt_y[2][MaxPoints];
    int unsigned              point_count[2];
    out_item_t                pending_moves[$];
    int                       errors;

    function new();
      point_count[0] = 0;
      point_count[1] = 0;
      errors         = 0;
    endfunction

    function void set_count(int idx, int unsigned val);
      point_count[idx] = val & 7'h7f;
    endfunction

    // floor(sqrt(d2) * 2^FractionBits)
    function longint unsigned fixed_root(longint unsigned d2);
      longint unsigned r, rem, pair, t;
      r   = 0;
      rem = 0;
      for (int i = 0; i < RootSteps; i++) begin
        pair = (i < 17) ? ((d2 >> (32 - 2 * i)) & 3) : 0;
        rem  = (rem << 2) | pair;
        t    = (r << 2) | 1;
        r    = r << 1;
        if (rem >= t) begin
          rem = rem - t;
          r   = r | 1;
        end
      end
      return r;
    endfunction

    // floor(a * 2^(2*FractionBits) / d)
    function longint unsigned fixed_quotient(longint unsigned a, longint unsigned d);
      longint unsigned q, r;
      q = 0;
      r = 0;
      for (int i = 0; i < DivSteps; i++) begin
        r = (r << 1) | ((i < 25) ? ((a >> (24 - i)) & 1) : 0);
        q = q << 1;
        if (r >= d) begin
          r = r - d;
          q = q | 1;
        end
      end
      return q;
    endfunction

    // Step one axis and truncate toward zero.
    function int step_axis(int pos, int delta, int unsigned speed, longint unsigned dis);
      longint unsigned mag;
      longint          step, sum;
      mag  = (delta < 0) ? -delta : delta;
      step = fixed_quotient(speed * mag, dis);
      if (delta < 0) step = -step;
      sum = (longint'(pos) <<< FractionBits) + step;
      if (sum >= 0) return int'(sum >>> FractionBits);
      return -int'((-sum) >>> FractionBits);
    endfunction

    function logic signed [CoordW-1:0] clamp16(int v);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[CoordW-1:0];
    endfunction

    // Note an accepted input beat; return the result it causes, if any.
    function void note_input(in_item_t it, output bit has_move, output out_item_t mv);
      int               sel, n, seg, px, py, x1, y1, x2, y2, dx, dy, nx, ny;
      longint unsigned  d2, dis;
      bit               snap;
      sel      = it.path_select;
      has_move = 0;
      mv       = '0;
      if (it.command == CMD_LOAD) begin
        pt_x[sel][it.point_slot] = it.point_x;
        pt_y[sel][it.point_slot] = it.point_y;
        return;
      end
      has_move = 1;
      n   = (point_count[sel] > MaxPoints) ? MaxPoints : point_count[sel];
      seg = (it.segment_in == 0) ? 1 : it.segment_in;
      px  = it.pos_x;
      py  = it.pos_y;
      if (n == 0) begin
        mv.next_x = it.pos_x;
        mv.next_y = it.pos_y;
        mv.arrived = 1'b1;
      end else if (seg >= n) begin
        mv.next_x      = pt_x[sel][n-1];
        mv.next_y      = pt_y[sel][n-1];
        mv.segment_out = CountW'(n);
        mv.arrived     = 1'b1;
      end else begin
        x1  = pt_x[sel][seg-1];
        y1  = pt_y[sel][seg-1];
        x2  = pt_x[sel][seg];
        y2  = pt_y[sel][seg];
        dx  = x2 - x1;
        dy  = y2 - y1;
        d2  = longint'(dx) * dx + longint'(dy) * dy;
        dis = fixed_root(d2);
        if (dis == 0) begin
          snap = 1;
        end else begin
          nx   = step_axis(px, dx, it.step_speed, dis);
          ny   = step_axis(py, dy, it.step_speed, dis);
          snap = nx < ((x1 < x2) ? x1 : x2) || nx > ((x1 > x2) ? x1 : x2) ||
                 ny < ((y1 < y2) ? y1 : y2) || ny > ((y1 > y2) ? y1 : y2) ||
                 (nx == x1 && ny == y1) || (nx == x2 && ny == y2);
        end
        if (snap) begin
          seg = seg + 1;
          nx  = x2;
          ny  = y2;
        end
        mv.next_x      = clamp16(nx);
        mv.next_y      = clamp16(ny);
        mv.segment_out = CountW'(seg);
        mv.arrived     = seg >= n;
      end
      pending_moves = {pending_moves, mv};
    endfunction

    function void report_field(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
        $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    // Compare a result beat with the oldest prediction.
    function void check(out_item_t got);
      out_item_t want;
      if (pending_moves.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %p", $time, got);
        errors++;
        return;
      end
      want = pending_moves.pop_front();
      report_field("next_x", want.next_x, got.next_x);
      report_field("next_y", want.next_y, got.next_y);
      report_field("segment_out", want.segment_out, got.segment_out);
      report_field("arrived", want.arrived, got.arrived);
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic               cfg_idx_i;
  logic [6:0]         cfg_wdata_i;
  logic               push;
  logic               full;
  in_item_t           in_item_i;
  logic               empty;
  logic               pop;
  out_item_t          out_item_o;

  path_scoreboard     sb;
  int                 burst_left;
  bit                 wide_coords;
  bit                 hold_req;
  // Mover walk state per path.
  int                 walk_seg[2];
  logic signed [15:0] walk_x[2];
  logic signed [15:0] walk_y[2];
  bit                 walk_done[2];

  waypoint_path_stepper u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item_i),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Send one beat; bursts with random gaps between them.
  task automatic send_item(in_item_t it);
    bit        has_move;
    out_item_t mv;
    int        gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_item_i <= it;
    push      <= 1'b1;
    do @(posedge clk_i); while (full);
    sb.note_input(it, has_move, mv);
    if (has_move && it.command == CMD_ADVANCE) begin
      walk_seg[it.path_select]  = mv.segment_out;
      walk_x[it.path_select]    = mv.next_x;
      walk_y[it.path_select]    = mv.next_y;
      walk_done[it.path_select] = mv.arrived;
    end
  endtask

  // Stop sending and wait for every predicted result.
  task automatic wait_drain();
    push <= 1'b0;
    while (sb.pending_moves.size() > 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(reg_idx_e idx, int unsigned val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val[6:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_count(idx, val);
  endtask

  function automatic logic [15:0] rand_coord();
    if (wide_coords) return 16'($urandom);
    return 16'($urandom_range(0, 400) - 200);
  endfunction

  function automatic in_item_t make_load(bit sel, int slot, logic [15:0] x, logic [15:0] y);
    in_item_t it;
    it             = '0;
    it.step_speed  = SpeedW'($urandom);
    it.pos_x       = CoordW'($urandom);
    it.pos_y       = CoordW'($urandom);
    it.segment_in  = CountW'($urandom);
    it.command     = CMD_LOAD;
    it.path_select = sel;
    it.point_slot  = SlotW'(slot);
    it.point_x     = x;
    it.point_y     = y;
    return it;
  endfunction

  function automatic in_item_t make_advance(bit sel, int seg, logic [15:0] x, logic [15:0] y,
                                            int speed);
    in_item_t it;
    it.point_x     = CoordW'($urandom);
    it.point_y     = CoordW'($urandom);
    it.point_slot  = SlotW'($urandom);
    it.command     = CMD_ADVANCE;
    it.path_select = sel;
    it.segment_in  = CountW'(seg);
    it.pos_x       = x;
    it.pos_y       = y;
    it.step_speed  = SpeedW'(speed);
    return it;
  endfunction

  // Set counts, fill the used slots, then run mixed beats.
  task automatic run_phase(int unsigned g_count, int unsigned a_count, int beats,
                           bit hold = 1'b0);
    int unsigned cnt[2];
    int          kind, sel, speed;
    wait_drain();
    repeat (120) @(posedge clk_i);
    cfg_write(REG_GROUND_COUNT, g_count);
    cfg_write(REG_AERIAL_COUNT, a_count);
    cnt[0]      = g_count;
    cnt[1]      = a_count;
    wide_coords = $urandom_range(0, 2) == 0;
    for (int s = 0; s < 2; s++) begin
      for (int k = 0; k < ((cnt[s] > MaxPoints) ? MaxPoints : cnt[s]); k++)
        send_item(make_load(1'(s), k, rand_coord(), rand_coord()));
      walk_done[s] = 1'b1;
    end
    // Ask the receiver to hold off while beats keep coming.
    if (hold) hold_req = 1'b1;
    for (int b = 0; b < beats; b++) begin
      kind  = $urandom_range(0, 99);
      sel   = $urandom_range(0, 1);
      speed = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 24);
      if (kind < 65) begin
        // Follow the path from the last predicted position.
        if (walk_done[sel]) begin
          walk_seg[sel]  = $urandom_range(0, 1);
          walk_x[sel]    = sb.pt_x[sel][0];
          walk_y[sel]    = sb.pt_y[sel][0];
          walk_done[sel] = 1'b0;
        end
        send_item(make_advance(1'(sel), walk_seg[sel], walk_x[sel], walk_y[sel], speed));
      end else if (kind < 85) begin
        send_item(make_advance(1'(sel), $urandom_range(0, 127), 16'($urandom),
                               16'($urandom), $urandom_range(0, 255)));
      end else begin
        send_item(make_load(1'(sel), $urandom_range(0, 63), rand_coord(), rand_coord()));
      end
    end
  endtask

  // Receiver: check beats and stall on a pattern of its own.
  initial begin
    int cyc, mode, hold_left;
    bit held;
    pop       = 1'b0;
    cyc       = 0;
    mode      = 0;
    hold_left = 0;
    held      = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) sb.check(out_item_o);
      if (hold_req && !held) begin
        held      = 1'b1;
        hold_left = 400;
      end
      if (cyc % 256 == 0) mode = $urandom_range(0, 3);
      cyc++;
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        case (mode)
          0: pop <= 1'b1;
          1: pop <= 1'($urandom_range(0, 1));
          2: pop <= ($urandom_range(0, 3) == 0);
          default: pop <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // Main sequence.
  initial begin
    sb          = new();
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = REG_GROUND_COUNT;
    cfg_wdata_i = '0;
    push        = 1'b0;
    in_item_i   = '0;
    burst_left  = 0;
    hold_req    = 1'b0;
    wide_coords = 1'b1;
    walk_done   = '{1'b1, 1'b1};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty path, zero-length segment, segment zero, extremes, last segment.
    send_item(make_advance(1'b0, 5, 16'h8000, 16'h7fff, 255));
    send_item(make_load(1'b0, 0, 16'h0000, 16'h0000));
    send_item(make_load(1'b0, 1, 16'h0000, 16'h0000));
    send_item(make_load(1'b0, 2, 16'h7fff, 16'h7fff));
    send_item(make_load(1'b0, 3, 16'h8000, 16'h8000));
    send_item(make_load(1'b1, 63, 16'hffff, 16'h8000));
    wait_drain();
    repeat (120) @(posedge clk_i);
    cfg_write(REG_GROUND_COUNT, 4);
    cfg_write(REG_AERIAL_COUNT, 0);
    send_item(make_advance(1'b0, 0, 16'h0000, 16'h0000, 255));
    send_item(make_advance(1'b0, 2, 16'h0000, 16'h0000, 0));
    send_item(make_advance(1'b0, 2, 16'd1000, 16'd1000, 255));
    send_item(make_advance(1'b0, 2, 16'h7ffe, 16'h7ffe, 255));
    send_item(make_advance(1'b0, 3, 16'h7fff, 16'h7fff, 255));
    send_item(make_advance(1'b0, 3, 16'h8001, 16'h8001, 1));
    send_item(make_advance(1'b0, 3, 16'd5, 16'd5, 0));
    send_item(make_advance(1'b0, 4, 16'd9, 16'd9, 7));
    send_item(make_advance(1'b0, 127, 16'h1234, 16'h4321, 128));
    send_item(make_advance(1'b1, 64, 16'h7fff, 16'h8000, 255));
    send_item(make_advance(1'b1, 0, 16'h8000, 16'h7fff, 0));

    run_phase(64, 64, 150);
    run_phase(2, 1, 150, 1'b1);
    run_phase(127, 3, 150);
    run_phase(0, 64, 130);
    run_phase($urandom_range(2, 20), $urandom_range(2, 20), 150);
    run_phase(1, 0, 110);
    run_phase($urandom_range(1, 64), $urandom_range(1, 64), 150);
    run_phase(64, 2, 150);

    wait_drain();
    repeat (150) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_moves.size() == 0) begin
      $display("waypoint_path_stepper_tb passed");
    end else begin
      $display("waypoint_path_stepper_tb failed");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #3_000_000;
    $display("waypoint_path_stepper_tb failed");
    $finish;
  end

endmodule
